// ===== sv/svc_pkg.sv =====
package svc_pkg;

    localparam int COIN_KINDS    = 4;
    localparam int STAMP_KINDS   = 3;
    localparam int COUNT_MAX_DEF = 255;

    // Stamp stock only ever goes down from its reset value, so three bits hold it.
    localparam int STAMP_CNT_W = 3;

    // Coin kind positions in the coin stock.
    localparam int COIN_FIVE    = 0;
    localparam int COIN_TEN     = 1;
    localparam int COIN_QUARTER = 2;

    localparam logic [7:0] COIN_DENOM [COIN_KINDS]  = '{8'd5, 8'd10, 8'd25, 8'd50};
    localparam logic [7:0] STAMP_DENOM [STAMP_KINDS] = '{8'd10, 8'd15, 8'd25};

    localparam int COIN_RST [COIN_KINDS] = '{4, 5, 5, 5};
    localparam logic [STAMP_CNT_W-1:0] STAMP_RST [STAMP_KINDS] = '{3'd5, 3'd5, 3'd4};

    // Change amounts that a legal coin and stamp pair can produce.
    localparam logic [7:0] CHG_TEN       = 8'd10;
    localparam logic [7:0] CHG_FIFTEEN   = 8'd15;
    localparam logic [7:0] CHG_QUARTER   = 8'd25;
    localparam logic [7:0] CHG_THIRTYFIVE = 8'd35;
    localparam logic [7:0] CHG_FORTY     = 8'd40;

    typedef enum logic [2:0] {
        ST_DISPENSED     = 3'd0,
        ST_ILLEGAL_COIN  = 3'd1,
        ST_UNKNOWN_STAMP = 3'd2,
        ST_INSUFFICIENT  = 3'd3,
        ST_SOLD_OUT      = 3'd4,
        ST_NO_CHANGE     = 3'd5
    } status_t;

    typedef struct packed {
        status_t                  status;
        logic [4:0]               stamp_given;
        logic                     change_fives;
        logic                     change_tens;
        logic                     change_quarters;
        logic [5:0]               refund_value;
        logic                     sell;
        logic [COIN_KINDS-1:0]    coin_hit;
        logic [STAMP_KINDS-1:0]   stamp_hit;
    } decision_t;

endpackage

// ===== sv/svc_decide.sv =====
module svc_decide
    import svc_pkg::*;
#(
    parameter int COUNT_W = 8
) (
    input  logic [7:0]             coin_value,
    input  logic [7:0]             stamp_value,
    input  logic [COUNT_W-1:0]     coin_cnt  [COIN_KINDS],
    input  logic [STAMP_CNT_W-1:0] stamp_cnt [STAMP_KINDS],
    output decision_t              dec
);

    logic [COIN_KINDS-1:0]  coin_hit;
    logic [STAMP_KINDS-1:0] stamp_hit;
    logic                   stamp_left;
    logic [7:0]             diff;
    logic                   f, t, q;
    logic                   can_pay;

    always_comb begin
        stamp_left = 1'b0;
        for (int i = 0; i < COIN_KINDS; i++) begin
            coin_hit[i] = (coin_value == COIN_DENOM[i]);
        end
        for (int i = 0; i < STAMP_KINDS; i++) begin
            stamp_hit[i] = (stamp_value == STAMP_DENOM[i]);
            stamp_left   = stamp_left | (stamp_hit[i] && (stamp_cnt[i] != '0));
        end

        diff = coin_value - stamp_value;
        f = 1'b0;
        t = 1'b0;
        q = 1'b0;
        unique case (diff)
            CHG_TEN:        t = 1'b1;
            CHG_FIFTEEN: begin
                f = 1'b1;
                t = 1'b1;
            end
            CHG_QUARTER:    q = 1'b1;
            CHG_THIRTYFIVE: begin
                t = 1'b1;
                q = 1'b1;
            end
            CHG_FORTY: begin
                f = 1'b1;
                t = 1'b1;
                q = 1'b1;
            end
            default: ;
        endcase
        can_pay = !(f && coin_cnt[COIN_FIVE] == '0)
               && !(t && coin_cnt[COIN_TEN] == '0)
               && !(q && coin_cnt[COIN_QUARTER] == '0);

        dec                 = '0;
        dec.coin_hit        = coin_hit;
        dec.stamp_hit       = stamp_hit;
        // Checks are reported in order: coin, stamp, amount, stock, change.
        priority if (coin_hit == '0) begin
            dec.status = ST_ILLEGAL_COIN;
        end else if (stamp_hit == '0) begin
            dec.status = ST_UNKNOWN_STAMP;
        end else if (coin_value < stamp_value) begin
            dec.status = ST_INSUFFICIENT;
        end else if (!stamp_left) begin
            dec.status       = ST_SOLD_OUT;
            dec.refund_value = coin_value[5:0];
        end else if (!can_pay) begin
            dec.status       = ST_NO_CHANGE;
            dec.refund_value = coin_value[5:0];
        end else begin
            dec.status          = ST_DISPENSED;
            dec.sell            = 1'b1;
            dec.stamp_given     = stamp_value[4:0];
            dec.change_fives    = f;
            dec.change_tens     = t;
            dec.change_quarters = q;
        end
    end

endmodule

// ===== sv/stamp_vending_controller_unit.sv =====
// Stamp vending controller: each input beat is one sale attempt (a coin and a requested
// stamp) and produces exactly one result beat with the status, the stamp handed out, the
// change coins and any refund. The unit takes one beat per cycle unless the result side
// stalls. A beat is held in an input register, then decided against the coin and stamp
// stock as it moves into the result register, where the stock is updated in the same
// cycle, so each beat sees the stock left by the beat before it. A stall on the result
// side holds both registers; the input side stays ready while the input register is
// empty or the result can move on. Coin stock counts saturate at COUNT_MAX.
module stamp_vending_controller_unit
    import svc_pkg::*;
#(
    parameter int COUNT_MAX = COUNT_MAX_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_coin_value,
    input  logic [7:0] s_stamp_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [4:0] m_stamp_given,
    output logic       m_change_fives,
    output logic       m_change_tens,
    output logic       m_change_quarters,
    output logic [5:0] m_refund_value
);

    localparam int COUNT_W = $clog2(COUNT_MAX + 1);

    logic                   in_valid_reg;
    logic [7:0]             coin_reg, stamp_reg;
    logic                   out_valid_reg;
    status_t                status_reg;
    logic [4:0]             given_reg;
    logic                   fives_reg, tens_reg, quarters_reg;
    logic [5:0]             refund_reg;
    logic [COUNT_W-1:0]     coin_cnt_reg  [COIN_KINDS];
    logic [COUNT_W-1:0]     coin_cnt_next [COIN_KINDS];
    logic [STAMP_CNT_W-1:0] stamp_cnt_reg  [STAMP_KINDS];
    logic [STAMP_CNT_W-1:0] stamp_cnt_next [STAMP_KINDS];
    logic [COUNT_W-1:0]     coin_tmp;
    logic [COIN_KINDS-1:0]  pay_dec;
    decision_t              dec;
    logic                   advance, commit;

    assign advance = !out_valid_reg || m_ready;
    assign commit  = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    svc_decide #(
        .COUNT_W (COUNT_W)
    ) u_decide (
        .coin_value  (coin_reg),
        .stamp_value (stamp_reg),
        .coin_cnt    (coin_cnt_reg),
        .stamp_cnt   (stamp_cnt_reg),
        .dec         (dec)
    );

    always_comb begin
        pay_dec = '0;
        pay_dec[COIN_FIVE]    = dec.change_fives;
        pay_dec[COIN_TEN]     = dec.change_tens;
        pay_dec[COIN_QUARTER] = dec.change_quarters;
        for (int k = 0; k < COIN_KINDS; k++) begin
            coin_tmp = coin_cnt_reg[k] - COUNT_W'(pay_dec[k]);
            coin_cnt_next[k] = coin_tmp;
            if (dec.sell && dec.coin_hit[k] && coin_tmp < COUNT_W'(COUNT_MAX)) begin
                coin_cnt_next[k] = coin_tmp + COUNT_W'(1);
            end
        end
        for (int k = 0; k < STAMP_KINDS; k++) begin
            stamp_cnt_next[k] = stamp_cnt_reg[k]
                              - STAMP_CNT_W'(dec.sell && dec.stamp_hit[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < COIN_KINDS; k++) begin
                coin_cnt_reg[k] <= COUNT_W'(COIN_RST[k]);
            end
            for (int k = 0; k < STAMP_KINDS; k++) begin
                stamp_cnt_reg[k] <= STAMP_RST[k];
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (commit) begin
                coin_cnt_reg  <= coin_cnt_next;
                stamp_cnt_reg <= stamp_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            coin_reg  <= s_coin_value;
            stamp_reg <= s_stamp_value;
        end
        if (commit) begin
            status_reg   <= dec.status;
            given_reg    <= dec.stamp_given;
            fives_reg    <= dec.change_fives;
            tens_reg     <= dec.change_tens;
            quarters_reg <= dec.change_quarters;
            refund_reg   <= dec.refund_value;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = status_reg;
    assign m_stamp_given     = given_reg;
    assign m_change_fives    = fives_reg;
    assign m_change_tens     = tens_reg;
    assign m_change_quarters = quarters_reg;
    assign m_refund_value    = refund_reg;

`ifndef SYNTH
    logic [STAMP_CNT_W+1:0] stamp_total;
    assign stamp_total = (STAMP_CNT_W+2)'(stamp_cnt_reg[0]) + (STAMP_CNT_W+2)'(stamp_cnt_reg[1])
                       + (STAMP_CNT_W+2)'(stamp_cnt_reg[2]);

    a_stamp_stock_falls: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (stamp_total <= $past(stamp_total)))
        else $error("stamp stock grew");

    a_sale_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_DISPENSED) |-> (m_stamp_given != '0 && m_refund_value == '0))
        else $error("sale beat without stamp or with refund");

    a_no_change_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_DISPENSED)
        |-> (!m_change_fives && !m_change_tens && !m_change_quarters && m_stamp_given == '0))
        else $error("change or stamp paid on a failed sale");
`endif

endmodule

// ===== tb/tb_stamp_vending_controller_unit.sv =====
module tb_stamp_vending_controller_unit;
    import svc_pkg::*;

    localparam int RANDOM_SALES = 1800;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        status_t    status;
        logic [4:0] stamp_given;
        logic       fives;
        logic       tens;
        logic       quarters;
        logic [5:0] refund;
    } receipt_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_coin_value;
    logic [7:0] s_stamp_value;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_status;
    logic [4:0] m_stamp_given;
    logic       m_change_fives;
    logic       m_change_tens;
    logic       m_change_quarters;
    logic [5:0] m_refund_value;

    // Shadow of the machine's stock, updated as each sale beat is accepted.
    int coin_stock [COIN_KINDS];
    int stamp_stock [STAMP_KINDS];

    receipt_t expected_receipts [$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       sender_calm = 0;
    int       taker_calm = 0;

    stamp_vending_controller_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_coin_value      (s_coin_value),
        .s_stamp_value     (s_stamp_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_stamp_given     (m_stamp_given),
        .m_change_fives    (m_change_fives),
        .m_change_tens     (m_change_tens),
        .m_change_quarters (m_change_quarters),
        .m_refund_value    (m_refund_value)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Draws a random wait, with occasional streaks of back-to-back beats.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(8, 40);
        return $urandom_range(0, 6);
    endfunction

    function automatic receipt_t vend_predict(input logic [7:0] coin, input logic [7:0] stamp);
        receipt_t   r;
        int         ci;
        int         si;
        logic [7:0] change;
        logic       f;
        logic       t;
        logic       q;
        r  = '0;
        ci = -1;
        si = -1;
        f  = 1'b0;
        t  = 1'b0;
        q  = 1'b0;
        for (int i = 0; i < COIN_KINDS; i++)
            if (COIN_DENOM[i] == coin) ci = i;
        for (int i = 0; i < STAMP_KINDS; i++)
            if (STAMP_DENOM[i] == stamp) si = i;
        if (ci < 0) begin
            r.status = ST_ILLEGAL_COIN;
        end else if (si < 0) begin
            r.status = ST_UNKNOWN_STAMP;
        end else if (coin < stamp) begin
            r.status = ST_INSUFFICIENT;
        end else if (stamp_stock[si] == 0) begin
            r.status = ST_SOLD_OUT;
            r.refund = coin[5:0];
        end else begin
            change = coin - stamp;
            case (change)
                CHG_TEN: t = 1'b1;
                CHG_FIFTEEN: begin
                    f = 1'b1;
                    t = 1'b1;
                end
                CHG_QUARTER: q = 1'b1;
                CHG_THIRTYFIVE: begin
                    t = 1'b1;
                    q = 1'b1;
                end
                CHG_FORTY: begin
                    f = 1'b1;
                    t = 1'b1;
                    q = 1'b1;
                end
                default: ;
            endcase
            if ((f && coin_stock[COIN_FIVE] == 0) || (t && coin_stock[COIN_TEN] == 0) ||
                (q && coin_stock[COIN_QUARTER] == 0)) begin
                r.status = ST_NO_CHANGE;
                r.refund = coin[5:0];
            end else begin
                // Change comes out of the stock before the inserted coin is banked.
                coin_stock[COIN_FIVE]    -= int'(f);
                coin_stock[COIN_TEN]     -= int'(t);
                coin_stock[COIN_QUARTER] -= int'(q);
                if (coin_stock[ci] < COUNT_MAX_DEF)
                    coin_stock[ci]++;
                stamp_stock[si]--;
                r.status      = ST_DISPENSED;
                r.stamp_given = stamp[4:0];
                r.fives       = f;
                r.tens        = t;
                r.quarters    = q;
            end
        end
        return r;
    endfunction

    task automatic send_sale(input logic [7:0] coin, input logic [7:0] stamp);
        int gap;
        gap = draw_wait(sender_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_coin_value  <= coin;
        s_stamp_value <= stamp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_receipts.push_back(vend_predict(coin, stamp));
    endtask

    task automatic wait_for_receipts();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_receipts.size() != 0);
    endtask

    task automatic check_field(input string name, input int exp, input int act);
        if (exp != act) begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            mismatch_count++;
        end
    endtask

    // Result side: random stalls, then one check per accepted beat.
    initial begin : receipt_checker
        receipt_t want;
        int       stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = draw_wait(taker_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (expected_receipts.size() == 0) begin
                $error("result beat with no sale pending: status %0d", m_status);
                mismatch_count++;
            end else begin
                want = expected_receipts.pop_front();
                check_field("status", want.status, m_status);
                check_field("stamp_given", want.stamp_given, m_stamp_given);
                check_field("change_fives", want.fives, m_change_fives);
                check_field("change_tens", want.tens, m_change_tens);
                check_field("change_quarters", want.quarters, m_change_quarters);
                check_field("refund_value", want.refund, m_refund_value);
            end
        end
    end

    // Rejections at the field extremes, and the order in which the checks apply.
    task automatic test_rejects();
        send_sale(8'd0, 8'd10);
        send_sale(8'd255, 8'd255);
        send_sale(8'd7, 8'd99);
        send_sale(8'd50, 8'd0);
        send_sale(8'd10, 8'd255);
        send_sale(8'd10, 8'd99);
        send_sale(8'd5, 8'd10);
        send_sale(8'd10, 8'd15);
        send_sale(8'd10, 8'd25);
    endtask

    // Walks the stock down so that change is paid while the coins last and refused
    // once a needed coin runs out, and ends with a sold out stamp.
    task automatic test_change_paths();
        repeat (4) send_sale(8'd50, 8'd10);
        send_sale(8'd25, 8'd10);
        send_sale(8'd50, 8'd15);
        send_sale(8'd25, 8'd15);
        send_sale(8'd50, 8'd25);
        send_sale(8'd10, 8'd10);
        send_sale(8'd10, 8'd10);
        send_sale(8'd25, 8'd25);
        send_sale(8'd50, 8'd25);
        send_sale(8'd25, 8'd15);
        // Sold out wins over a change that could not be paid either.
        send_sale(8'd50, 8'd10);
    endtask

    function automatic logic [7:0] legal_coin();
        return COIN_DENOM[$urandom_range(0, COIN_KINDS - 1)];
    endfunction

    function automatic logic [7:0] legal_stamp();
        return STAMP_DENOM[$urandom_range(0, STAMP_KINDS - 1)];
    endfunction

    // The sender holds off until the pipeline is empty, then resumes.
    task automatic test_drain_pause();
        repeat (6) send_sale(legal_coin(), legal_stamp());
        wait_for_receipts();
        repeat (6) send_sale(legal_coin(), legal_stamp());
    endtask

    task automatic test_random_sales();
        int pick;
        repeat (RANDOM_SALES) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_sale(legal_coin(), legal_stamp());
            else if (pick < 75)
                send_sale(legal_coin(), 8'($urandom));
            else if (pick < 85)
                send_sale(8'($urandom), legal_stamp());
            else
                send_sale(8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        s_valid       <= 1'b0;
        s_coin_value  <= 8'd0;
        s_stamp_value <= 8'd0;
        aresetn       <= 1'b0;
        coin_stock = COIN_RST;
        for (int i = 0; i < STAMP_KINDS; i++)
            stamp_stock[i] = int'(STAMP_RST[i]);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_rejects();
        test_change_paths();
        test_drain_pause();
        test_random_sales();
        wait_for_receipts();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/svc_pkg.sv
sv/svc_decide.sv
sv/stamp_vending_controller_unit.sv
tb/tb_stamp_vending_controller_unit.sv
